@@ hdl/brp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bit repacker package
// Shared types, register indexes and bit helpers for the bit repacker.
// ============================================================================
package brp_pkg;

    localparam int MAX_SYMBOL_BITS = 8;
    localparam int WIDTH_W         = 4;
    localparam int INDEX_W         = 3;
    localparam int QDEPTH          = 2;

    localparam logic [INDEX_W-1:0] REG_IN_BITS      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_OUT_BITS     = 3'd1;
    localparam logic [INDEX_W-1:0] REG_MSB_FIRST    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_PACKET_MODE  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_TRIM_TAIL    = 3'd4;

    localparam logic [WIDTH_W-1:0] IN_BITS_RESET  = 4'd8;
    localparam logic [WIDTH_W-1:0] OUT_BITS_RESET = 4'd1;

    typedef struct packed {
        logic [WIDTH_W-1:0] in_bits;
        logic [WIDTH_W-1:0] out_bits;
        logic               msb_first;
        logic               packet_mode;
        logic               trim_tail;
    } cfg_t;

    // symbol in stream order: bit 0 is the first bit to be packed
    typedef struct packed {
        logic [7:0]         bits;
        logic [WIDTH_W-1:0] count;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       packet_last;
    } result_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        if (v == '0)
            r = WIDTH_W'(1);
        else if (v > WIDTH_W'(MAX_SYMBOL_BITS))
            r = WIDTH_W'(MAX_SYMBOL_BITS);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [7:0] low_mask(input logic [WIDTH_W-1:0] n);
        logic [8:0] m;
        m = (9'd1 << n) - 9'd1;
        return m[7:0];
    endfunction

endpackage

@@ hdl/brp_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bit repacker front end
// Accepts input beats, puts the symbol bits in stream order and queues them.
// ============================================================================
module brp_front
    import brp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       packet_end,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_pop
);

    item_t      mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      in_item;
    logic       wr_en;
    logic       rd_en;

    always_comb
    begin
        in_item.count = cfg.in_bits;
        in_item.last  = packet_end & cfg.packet_mode;
        if (cfg.msb_first)
            in_item.bits = rev8(data_byte) >> (WIDTH_W'(MAX_SYMBOL_BITS) - cfg.in_bits);
        else
            in_item.bits = data_byte & low_mask(cfg.in_bits);
    end

    assign full       = (count_reg == 2'(QDEPTH));
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign wr_en      = push & ~full;
    assign rd_en      = item_pop & item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("front queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg <= 2'd1))
        else $error("front queue underflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("front queue lost a beat");

endmodule

@@ hdl/brp_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bit repacker back end
// Packs queued symbol bits into output groups; stalls while the output queue is full.
// ============================================================================
module brp_back
    import brp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       clear_partial,
    input  logic       item_valid,
    input  item_t      item,
    output logic       item_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       packet_last
);

    logic [7:0]         group_reg, group_next;
    logic [2:0]         pcount_reg, pcount_next;
    logic               cur_valid_reg, cur_valid_next;
    item_t              cur_reg, cur_next;

    result_t            oq_mem_reg [QDEPTH];
    logic               oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [1:0]         oq_count_reg, oq_count_next;

    item_t              act;
    logic               go;
    logic [WIDTH_W-1:0] c_ext;
    logic [WIDTH_W-1:0] room;
    logic [WIDTH_W-1:0] take;
    logic [7:0]         chunk;
    logic [7:0]         placed;
    logic [7:0]         new_group;
    logic [WIDTH_W-1:0] c2;
    logic [WIDTH_W-1:0] m2;
    logic               grp_full;
    logic               done;
    logic               more_out;
    logic               emit;
    result_t            res;
    logic               oq_rd;

    always_comb
    begin
        act       = cur_valid_reg ? cur_reg : item;
        go        = (cur_valid_reg | item_valid) & (oq_count_reg != 2'(QDEPTH));
        c_ext     = WIDTH_W'(pcount_reg);
        room      = cfg.out_bits - c_ext;
        take      = (room < act.count) ? room : act.count;
        chunk     = act.bits & low_mask(take);
        if (cfg.msb_first)
            placed = rev8(chunk) >> (WIDTH_W'(MAX_SYMBOL_BITS) - cfg.out_bits + c_ext);
        else
            placed = chunk << pcount_reg;
        new_group = group_reg | placed;
        c2        = c_ext + take;
        m2        = act.count - take;
        grp_full  = (c2 == cfg.out_bits);
        done      = (m2 == '0);
        // another beat follows from this item if the rest fills a group or is flushed
        more_out  = (m2 >= cfg.out_bits) | (~done & act.last & ~cfg.trim_tail);

        emit            = 1'b0;
        res.out_byte    = new_group;
        res.run_last    = ~more_out;
        res.packet_last = ~more_out & act.last;
        group_next      = group_reg;
        pcount_next     = pcount_reg;
        cur_valid_next  = cur_valid_reg;
        cur_next        = cur_reg;

        if (go)
        begin
            if (grp_full)
            begin
                emit        = 1'b1;
                group_next  = '0;
                pcount_next = '0;
            end
            else if (act.last)
            begin
                emit        = ~cfg.trim_tail;
                group_next  = '0;
                pcount_next = '0;
            end
            else
            begin
                group_next  = new_group;
                pcount_next = c2[2:0];
            end

            cur_valid_next = ~done;
            cur_next.bits  = act.bits >> take;
            cur_next.count = m2;
            cur_next.last  = act.last;
        end

        if (clear_partial)
        begin
            group_next  = '0;
            pcount_next = '0;
        end
    end

    assign item_pop = go & ~cur_valid_reg;

    // output queue
    assign empty       = (oq_count_reg == 2'd0);
    assign oq_rd       = pop & ~empty;
    assign out_byte    = oq_mem_reg[oq_rd_ptr_reg].out_byte;
    assign run_last    = oq_mem_reg[oq_rd_ptr_reg].run_last;
    assign packet_last = oq_mem_reg[oq_rd_ptr_reg].packet_last;
    assign oq_count_next = oq_count_reg + 2'(emit) - 2'(oq_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg     <= '0;
            pcount_reg    <= '0;
            cur_valid_reg <= 1'b0;
            oq_wr_ptr_reg <= 1'b0;
            oq_rd_ptr_reg <= 1'b0;
            oq_count_reg  <= 2'd0;
        end
        else
        begin
            group_reg     <= group_next;
            pcount_reg    <= pcount_next;
            cur_valid_reg <= cur_valid_next;
            oq_wr_ptr_reg <= oq_wr_ptr_reg ^ emit;
            oq_rd_ptr_reg <= oq_rd_ptr_reg ^ oq_rd;
            oq_count_reg  <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            oq_mem_reg[oq_wr_ptr_reg] <= res;
        end
    end

    a_partial_below_width: assert property (@(posedge clk) disable iff (!rst_n)
        WIDTH_W'(pcount_reg) < cfg.out_bits)
        else $error("partial group reached output width");

    a_no_oq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (oq_count_reg != 2'(QDEPTH)))
        else $error("output queue overflow");

    a_packet_last_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res.packet_last) |-> res.run_last)
        else $error("packet end not on last beat of item");

    a_remainder_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.count != '0))
        else $error("held item with no bits left");

endmodule

@@ hdl/bit_repacker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bit repacker
// Regroups symbols of in_bits bits into output bytes of out_bits bits.
// ============================================================================
// A beat is registered in the front queue; the groups it completes are
// registered in the output queue before they reach the outputs.
// The back end works on one beat at a time and takes the next only once all
// bits of the current one are used; it stalls only while the two-entry output
// queue is full.
// Reset clears both queues and the partial group, and loads in_bits 8,
// out_bits 1 and the flags at zero.
module bit_repacker
    import brp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [WIDTH_W-1:0] wr_data,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    input  logic               packet_end,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               packet_last
);

    cfg_t  cfg_reg, cfg_next;
    logic  clear_partial;
    logic  item_valid;
    item_t item;
    logic  item_pop;

    always_comb
    begin
        cfg_next      = cfg_reg;
        clear_partial = 1'b0;
        if (wr_en)
        begin
            case (wr_index)
                REG_IN_BITS:
                begin
                    cfg_next.in_bits = clamp_width(wr_data);
                    clear_partial    = 1'b1;
                end
                REG_OUT_BITS:
                begin
                    cfg_next.out_bits = clamp_width(wr_data);
                    clear_partial     = 1'b1;
                end
                REG_MSB_FIRST:    cfg_next.msb_first    = wr_data[0];
                REG_PACKET_MODE:  cfg_next.packet_mode  = wr_data[0];
                REG_TRIM_TAIL:    cfg_next.trim_tail    = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_bits      <= IN_BITS_RESET;
            cfg_reg.out_bits     <= OUT_BITS_RESET;
            cfg_reg.msb_first    <= 1'b0;
            cfg_reg.packet_mode  <= 1'b0;
            cfg_reg.trim_tail    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .packet_end (packet_end),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    brp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .clear_partial (clear_partial),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .packet_last   (packet_last)
    );

endmodule
